// ===== rtl/core/aehh_pkg.sv =====
// Shared types and constants for the absolute-error heat map and histogram block.
`default_nettype none

package aehh_pkg;

   // One lane per color channel.
   localparam int NUM_LANES = 3;

   localparam int CHAN_W  = 8;
   localparam int ERR_W   = 10;
   localparam int ACCUM_W = 32;
   localparam int TALLY_W = 23;

   // Error level at which one heat channel is full and the next one starts.
   localparam logic [ERR_W-1:0] HEAT_STEP     = 10'd255;
   localparam logic [ERR_W-1:0] HEAT_STEP_TWO = 10'd510;

   localparam logic [ERR_W-1:0] MIDDLE_BOUND_RESET = 10'd382;

   // Largest value a tally can hold.
   localparam logic [TALLY_W-1:0] TALLY_CEILING = 23'd8388607;

   typedef enum logic [1:0] {
      BIN_EXACT  = 2'd0,
      BIN_MIDDLE = 2'd1,
      BIN_BAD    = 2'd2
   } bin_type;

   // Merged per-pixel result handed from the merge stage to the statistics stage.
   typedef struct packed {
      logic              valid;
      logic              frame_start;
      logic [ERR_W-1:0]  pixel_error;
      logic [CHAN_W-1:0] heat_ch0;
      logic [CHAN_W-1:0] heat_ch1;
      logic [CHAN_W-1:0] heat_ch2;
      bin_type           bin;
   } merge_out_type;

endpackage

`default_nettype wire

// ===== rtl/core/abs_error_heatmap_histogram.sv =====
// Top level: per-pixel RGB absolute error, heat color and per-frame error histogram.
// Usage:
//   req_* carries one transaction per pixel: a reference and a test RGB pixel plus a
//   frame-start flag. rsp_* returns one transaction per pixel, in order: the pixel
//   error (sum of the three absolute channel differences), a three-channel heat color
//   and the running frame totals (saturating error sum, exact/middle/bad bin counts)
//   with this pixel included. csr_wr_en/csr_wr_data load middle_bound, the largest
//   error that still counts in the middle bin; write it only while the block is idle.
//   From req acceptance to rsp_valid a pixel passes the registers of the three
//   channel lanes, the merge stage (sum, heat, bin select) and the statistics stage,
//   whose registers also hold the result. Throughput is one pixel per cycle when not
//   stalled; the statistics update is a single saturating add per cycle.
//   When rsp_stall is high with a result waiting, the whole pipeline holds and
//   req_stall rises in the same cycle; bubbles drain without stalling the input.
//   Reset (synchronous) drops all in-flight transactions, zeroes the frame totals
//   and sets middle_bound to 382.
`default_nettype none

module abs_error_heatmap_histogram #(
   parameter int MAX_PIXELS = 4194304
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic [9:0]  csr_wr_data,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_frame_start,
   input  wire logic [7:0]  req_ref_ch0,
   input  wire logic [7:0]  req_ref_ch1,
   input  wire logic [7:0]  req_ref_ch2,
   input  wire logic [7:0]  req_test_ch0,
   input  wire logic [7:0]  req_test_ch1,
   input  wire logic [7:0]  req_test_ch2,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [9:0]       rsp_pixel_error,
   output logic [7:0]       rsp_heat_ch0,
   output logic [7:0]       rsp_heat_ch1,
   output logic [7:0]       rsp_heat_ch2,
   output logic [31:0]      rsp_error_total,
   output logic [22:0]      rsp_exact_count,
   output logic [22:0]      rsp_middle_count,
   output logic [22:0]      rsp_bad_count
);

   logic                                  advance;
   logic [aehh_pkg::ERR_W-1:0]            middle_bound_ff;
   logic                                  s1_valid_ff;
   logic                                  s1_frame_ff;
   logic [aehh_pkg::CHAN_W-1:0]           ref_chan  [aehh_pkg::NUM_LANES];
   logic [aehh_pkg::CHAN_W-1:0]           test_chan [aehh_pkg::NUM_LANES];
   logic [aehh_pkg::CHAN_W-1:0]           lane_diff [aehh_pkg::NUM_LANES];
   aehh_pkg::merge_out_type               merge_out;

   // Advance every stage unless a finished result is being held by the receiver.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         middle_bound_ff <= aehh_pkg::MIDDLE_BOUND_RESET;
      end else if (csr_wr_en) begin
         middle_bound_ff <= csr_wr_data;
      end
   end

   // Lane stage control: valid and frame flag travel alongside the lane registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_frame_ff <= req_frame_start;
      end
   end

   assign ref_chan[0]  = req_ref_ch0;
   assign ref_chan[1]  = req_ref_ch1;
   assign ref_chan[2]  = req_ref_ch2;
   assign test_chan[0] = req_test_ch0;
   assign test_chan[1] = req_test_ch1;
   assign test_chan[2] = req_test_ch2;

   // One lane per color channel, side by side.
   for (genvar g = 0; g < aehh_pkg::NUM_LANES; g++) begin : g_lane
      aehh_lane u_lane (
         .clock     (clock),
         .enable    (advance),
         .ref_val   (ref_chan[g]),
         .test_val  (test_chan[g]),
         .lane_diff (lane_diff[g])
      );
   end

   // Combine the lanes into the pixel error, heat color and bin.
   aehh_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .enable         (advance),
      .valid_in       (s1_valid_ff),
      .frame_start_in (s1_frame_ff),
      .lane_diff      (lane_diff),
      .middle_bound   (middle_bound_ff),
      .stage_out      (merge_out)
   );

   // Frame statistics; its registers are the output register of the rsp channel.
   aehh_stats #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_stats (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .stage_in     (merge_out),
      .out_valid    (rsp_valid),
      .pixel_error  (rsp_pixel_error),
      .heat_ch0     (rsp_heat_ch0),
      .heat_ch1     (rsp_heat_ch1),
      .heat_ch2     (rsp_heat_ch2),
      .error_total  (rsp_error_total),
      .exact_count  (rsp_exact_count),
      .middle_count (rsp_middle_count),
      .bad_count    (rsp_bad_count)
   );

endmodule

`default_nettype wire

// ===== rtl/core/aehh_lane.sv =====
// One channel lane: absolute difference of a reference and a test sample.
`default_nettype none

module aehh_lane (
   input  wire logic                      clock,
   input  wire logic                      enable,
   input  wire logic [aehh_pkg::CHAN_W-1:0] ref_val,
   input  wire logic [aehh_pkg::CHAN_W-1:0] test_val,
   output logic      [aehh_pkg::CHAN_W-1:0] lane_diff
);

   logic [aehh_pkg::CHAN_W-1:0] diff_in;
   logic [aehh_pkg::CHAN_W-1:0] diff_ff;

   always_comb begin
      if (ref_val >= test_val) begin
         diff_in = ref_val - test_val;
      end else begin
         diff_in = test_val - ref_val;
      end
   end

   // Hold while the pipeline is stalled.
   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff <= diff_in;
      end
   end

   assign lane_diff = diff_ff;

endmodule

`default_nettype wire

// ===== rtl/core/aehh_merge.sv =====
// Merge stage: sums the lane differences, builds the heat color and picks the bin.
`default_nettype none

module aehh_merge (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          valid_in,
   input  wire logic                          frame_start_in,
   input  wire logic [aehh_pkg::CHAN_W-1:0]   lane_diff [aehh_pkg::NUM_LANES],
   input  wire logic [aehh_pkg::ERR_W-1:0]    middle_bound,
   output aehh_pkg::merge_out_type            stage_out
);

   logic [aehh_pkg::ERR_W-1:0] err;
   aehh_pkg::merge_out_type    stage_in;
   aehh_pkg::merge_out_type    stage_ff;

   assign err = aehh_pkg::ERR_W'(lane_diff[0]) + aehh_pkg::ERR_W'(lane_diff[1])
              + aehh_pkg::ERR_W'(lane_diff[2]);

   always_comb begin
      stage_in             = '0;
      stage_in.valid       = valid_in;
      stage_in.frame_start = frame_start_in;
      stage_in.pixel_error = err;

      // Fill channel 0, then 1, then 2.
      if (err < aehh_pkg::HEAT_STEP) begin
         stage_in.heat_ch0 = err[aehh_pkg::CHAN_W-1:0];
      end else if (err < aehh_pkg::HEAT_STEP_TWO) begin
         stage_in.heat_ch0 = '1;
         stage_in.heat_ch1 = aehh_pkg::CHAN_W'(err - aehh_pkg::HEAT_STEP);
      end else begin
         stage_in.heat_ch0 = '1;
         stage_in.heat_ch1 = '1;
         stage_in.heat_ch2 = aehh_pkg::CHAN_W'(err - aehh_pkg::HEAT_STEP_TWO);
      end

      if (err == '0) begin
         stage_in.bin = aehh_pkg::BIN_EXACT;
      end else if (err <= middle_bound) begin
         stage_in.bin = aehh_pkg::BIN_MIDDLE;
      end else begin
         stage_in.bin = aehh_pkg::BIN_BAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

// ===== rtl/core/aehh_stats.sv =====
// Statistics stage: saturating frame error sum, bin tallies and the output register.
`default_nettype none

module aehh_stats #(
   parameter int MAX_PIXELS = 4194304
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire aehh_pkg::merge_out_type       stage_in,
   output logic                               out_valid,
   output logic [aehh_pkg::ERR_W-1:0]         pixel_error,
   output logic [aehh_pkg::CHAN_W-1:0]        heat_ch0,
   output logic [aehh_pkg::CHAN_W-1:0]        heat_ch1,
   output logic [aehh_pkg::CHAN_W-1:0]        heat_ch2,
   output logic [aehh_pkg::ACCUM_W-1:0]       error_total,
   output logic [aehh_pkg::TALLY_W-1:0]       exact_count,
   output logic [aehh_pkg::TALLY_W-1:0]       middle_count,
   output logic [aehh_pkg::TALLY_W-1:0]       bad_count
);

   localparam logic [aehh_pkg::TALLY_W-1:0] TALLY_LIMIT =
      (MAX_PIXELS > 8388607) ? aehh_pkg::TALLY_CEILING : aehh_pkg::TALLY_W'(MAX_PIXELS);

   function automatic logic [aehh_pkg::TALLY_W-1:0] bump(
      input logic [aehh_pkg::TALLY_W-1:0] v
   );
      logic [aehh_pkg::TALLY_W-1:0] r;
      if (v >= TALLY_LIMIT) begin
         r = TALLY_LIMIT;
      end else begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   logic                             valid_ff;
   logic [aehh_pkg::ERR_W-1:0]       err_ff;
   logic [aehh_pkg::CHAN_W-1:0]      heat0_ff, heat1_ff, heat2_ff;
   logic [aehh_pkg::ACCUM_W-1:0]     accum_ff, accum_in, accum_base;
   logic [aehh_pkg::ACCUM_W:0]       accum_sum;
   logic [aehh_pkg::TALLY_W-1:0]     exact_ff, middle_ff, bad_ff;
   logic [aehh_pkg::TALLY_W-1:0]     exact_in, middle_in, bad_in;
   logic [aehh_pkg::TALLY_W-1:0]     exact_base, middle_base, bad_base;
   logic                             update;

   assign update = enable && stage_in.valid;

   always_comb begin
      // Clear the frame totals ahead of a frame-start pixel.
      accum_base  = stage_in.frame_start ? '0 : accum_ff;
      exact_base  = stage_in.frame_start ? '0 : exact_ff;
      middle_base = stage_in.frame_start ? '0 : middle_ff;
      bad_base    = stage_in.frame_start ? '0 : bad_ff;

      accum_sum = {1'b0, accum_base} + (aehh_pkg::ACCUM_W + 1)'(stage_in.pixel_error);
      accum_in  = accum_sum[aehh_pkg::ACCUM_W] ? '1 : accum_sum[aehh_pkg::ACCUM_W-1:0];

      exact_in  = exact_base;
      middle_in = middle_base;
      bad_in    = bad_base;
      case (stage_in.bin)
         aehh_pkg::BIN_EXACT:  exact_in  = bump(exact_base);
         aehh_pkg::BIN_MIDDLE: middle_in = bump(middle_base);
         aehh_pkg::BIN_BAD:    bad_in    = bump(bad_base);
         default: begin
            bad_in = bad_base;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         accum_ff  <= '0;
         exact_ff  <= '0;
         middle_ff <= '0;
         bad_ff    <= '0;
      end else begin
         if (enable) begin
            valid_ff <= stage_in.valid;
         end
         if (update) begin
            accum_ff  <= accum_in;
            exact_ff  <= exact_in;
            middle_ff <= middle_in;
            bad_ff    <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         err_ff   <= stage_in.pixel_error;
         heat0_ff <= stage_in.heat_ch0;
         heat1_ff <= stage_in.heat_ch1;
         heat2_ff <= stage_in.heat_ch2;
      end
   end

   assign out_valid    = valid_ff;
   assign pixel_error  = err_ff;
   assign heat_ch0     = heat0_ff;
   assign heat_ch1     = heat1_ff;
   assign heat_ch2     = heat2_ff;
   assign error_total  = accum_ff;
   assign exact_count  = exact_ff;
   assign middle_count = middle_ff;
   assign bad_count    = bad_ff;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for abs_error_heatmap_histogram: self-checking pixel stream with per-frame totals.

module tb_top;

   // Tally ceiling as built into the block.
   localparam int TB_MAX_PIXELS = 4194304;
   localparam logic [aehh_pkg::TALLY_W-1:0] TALLY_LIMIT =
      (TB_MAX_PIXELS < int'(aehh_pkg::TALLY_CEILING)) ?
         aehh_pkg::TALLY_W'(TB_MAX_PIXELS) : aehh_pkg::TALLY_CEILING;

   // Pipeline depth is 3; allow a little margin when draining.
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_ERR      = 765;
   localparam int LONG_RUN     = 54;

   typedef struct packed {
      logic              frame_start;
      logic [2:0][7:0]   ref_px;
      logic [2:0][7:0]   test_px;
   } pixel_type;

   typedef struct packed {
      logic [aehh_pkg::ERR_W-1:0]   pixel_error;
      logic [aehh_pkg::CHAN_W-1:0]  heat_ch0;
      logic [aehh_pkg::CHAN_W-1:0]  heat_ch1;
      logic [aehh_pkg::CHAN_W-1:0]  heat_ch2;
      logic [aehh_pkg::ACCUM_W-1:0] error_total;
      logic [aehh_pkg::TALLY_W-1:0] exact_count;
      logic [aehh_pkg::TALLY_W-1:0] middle_count;
      logic [aehh_pkg::TALLY_W-1:0] bad_count;
   } heat_stats_type;

   // ------------------------------------------------------------------
   // Clock, reset and DUT hookup
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   logic        csr_wr_en       = 1'b0;
   logic [9:0]  csr_wr_data     = '0;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_frame_start = 1'b0;
   logic [7:0]  req_ref_ch0     = '0;
   logic [7:0]  req_ref_ch1     = '0;
   logic [7:0]  req_ref_ch2     = '0;
   logic [7:0]  req_test_ch0    = '0;
   logic [7:0]  req_test_ch1    = '0;
   logic [7:0]  req_test_ch2    = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [9:0]  rsp_pixel_error;
   logic [7:0]  rsp_heat_ch0;
   logic [7:0]  rsp_heat_ch1;
   logic [7:0]  rsp_heat_ch2;
   logic [31:0] rsp_error_total;
   logic [22:0] rsp_exact_count;
   logic [22:0] rsp_middle_count;
   logic [22:0] rsp_bad_count;

   abs_error_heatmap_histogram #(
      .MAX_PIXELS(TB_MAX_PIXELS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_start  (req_frame_start),
      .req_ref_ch0      (req_ref_ch0),
      .req_ref_ch1      (req_ref_ch1),
      .req_ref_ch2      (req_ref_ch2),
      .req_test_ch0     (req_test_ch0),
      .req_test_ch1     (req_test_ch1),
      .req_test_ch2     (req_test_ch2),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_error  (rsp_pixel_error),
      .rsp_heat_ch0     (rsp_heat_ch0),
      .rsp_heat_ch1     (rsp_heat_ch1),
      .rsp_heat_ch2     (rsp_heat_ch2),
      .rsp_error_total  (rsp_error_total),
      .rsp_exact_count  (rsp_exact_count),
      .rsp_middle_count (rsp_middle_count),
      .rsp_bad_count    (rsp_bad_count)
   );

   // ------------------------------------------------------------------
   // Predictor state: mirrors the block's frame totals and its register
   // ------------------------------------------------------------------
   logic [aehh_pkg::ERR_W-1:0]   bound_mirror = aehh_pkg::MIDDLE_BOUND_RESET;
   logic [aehh_pkg::ACCUM_W-1:0] frame_error_sum;
   logic [aehh_pkg::TALLY_W-1:0] exact_seen;
   logic [aehh_pkg::TALLY_W-1:0] middle_seen;
   logic [aehh_pkg::TALLY_W-1:0] bad_seen;

   initial begin
      frame_error_sum = '0;
      exact_seen      = '0;
      middle_seen     = '0;
      bad_seen        = '0;
   end

   // One entry per accepted pixel, oldest first.
   heat_stats_type expected_heat[$];
   int             mismatch_count = 0;

   // Traffic shaping shared by the sender and the stall driver.
   bit no_idle      = 1'b0;
   bit hold_request = 1'b0;
   bit holding      = 1'b0;

   function automatic logic [aehh_pkg::TALLY_W-1:0] bump_tally(
      input logic [aehh_pkg::TALLY_W-1:0] v);
      if (v >= TALLY_LIMIT)
         return TALLY_LIMIT;
      return v + 1'b1;
   endfunction

   // Advance the frame totals by one pixel and return what the block must report.
   function automatic heat_stats_type predict_heat_stats(input pixel_type px);
      heat_stats_type               r;
      logic [aehh_pkg::ERR_W-1:0]   err;
      logic [7:0]                   a;
      logic [7:0]                   b;
      logic [aehh_pkg::ACCUM_W:0]   wide_sum;
      aehh_pkg::bin_type            bin;

      if (px.frame_start) begin
         frame_error_sum = '0;
         exact_seen      = '0;
         middle_seen     = '0;
         bad_seen        = '0;
      end

      err = '0;
      for (int ch = 0; ch < aehh_pkg::NUM_LANES; ch++) begin
         a = px.ref_px[ch];
         b = px.test_px[ch];
         err = err + aehh_pkg::ERR_W'((a >= b) ? (a - b) : (b - a));
      end

      // Heat fills channel 0, then 1, then 2.
      if (err < aehh_pkg::HEAT_STEP) begin
         r.heat_ch0 = err[7:0];
         r.heat_ch1 = '0;
         r.heat_ch2 = '0;
      end else if (err < aehh_pkg::HEAT_STEP_TWO) begin
         r.heat_ch0 = 8'hFF;
         r.heat_ch1 = 8'(err - aehh_pkg::HEAT_STEP);
         r.heat_ch2 = '0;
      end else begin
         r.heat_ch0 = 8'hFF;
         r.heat_ch1 = 8'hFF;
         r.heat_ch2 = 8'(err - aehh_pkg::HEAT_STEP_TWO);
      end

      // Saturating frame sum; the ceiling needs millions of pixels, so it is
      // modeled but not reached here.
      wide_sum = {1'b0, frame_error_sum} + (aehh_pkg::ACCUM_W+1)'(err);
      frame_error_sum = wide_sum[aehh_pkg::ACCUM_W] ? '1 : wide_sum[aehh_pkg::ACCUM_W-1:0];

      if (err == '0)
         bin = aehh_pkg::BIN_EXACT;
      else if (err <= bound_mirror)
         bin = aehh_pkg::BIN_MIDDLE;
      else
         bin = aehh_pkg::BIN_BAD;

      case (bin)
         aehh_pkg::BIN_EXACT:  exact_seen  = bump_tally(exact_seen);
         aehh_pkg::BIN_MIDDLE: middle_seen = bump_tally(middle_seen);
         default:              bad_seen    = bump_tally(bad_seen);
      endcase

      r.pixel_error  = err;
      r.error_total  = frame_error_sum;
      r.exact_count  = exact_seen;
      r.middle_count = middle_seen;
      r.bad_count    = bad_seen;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic pixel_type random_pixel(input bit fs);
      pixel_type px;
      px.frame_start = fs;
      for (int ch = 0; ch < 3; ch++) begin
         px.ref_px[ch]  = 8'($urandom);
         px.test_px[ch] = 8'($urandom);
      end
      return px;
   endfunction

   // Build a pixel pair whose summed channel difference is exactly err, with
   // random base levels and random sign per channel.
   function automatic pixel_type pixel_with_error(input int err, input bit fs);
      pixel_type px;
      int        left;
      int        d;
      int        lo;
      int        hi;
      int        base;

      left = (err > MAX_ERR) ? MAX_ERR : ((err < 0) ? 0 : err);
      px.frame_start = fs;
      for (int ch = 0; ch < 3; ch++) begin
         hi = (left > 255) ? 255 : left;
         lo = left - 255 * (2 - ch);
         if (lo < 0)
            lo = 0;
         d = (ch == 2) ? left : $urandom_range(hi, lo);
         base = $urandom_range(255 - d, 0);
         if ($urandom_range(1, 0) == 1) begin
            px.ref_px[ch]  = 8'(base + d);
            px.test_px[ch] = 8'(base);
         end else begin
            px.ref_px[ch]  = 8'(base);
            px.test_px[ch] = 8'(base + d);
         end
         left = left - d;
      end
      return px;
   endfunction

   // Pick an error on or next to a heat step, the bin bound or an end of the error range.
   function automatic int near_boundary();
      int pick;
      int b;
      b = int'(bound_mirror);
      pick = $urandom_range(6, 0);
      case (pick)
         0:       return $urandom_range(2, 0);
         1:       return $urandom_range(256, 254);
         2:       return $urandom_range(511, 509);
         3:       return $urandom_range(765, 763);
         default: return b + $urandom_range(2, 0) - 1;
      endcase
   endfunction

   // Offer one transaction, hold it until accepted, then record what it
   // must produce.
   task automatic send_pixel(input pixel_type px);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_start <= px.frame_start;
      req_ref_ch0     <= px.ref_px[0];
      req_ref_ch1     <= px.ref_px[1];
      req_ref_ch2     <= px.ref_px[2];
      req_test_ch0    <= px.test_px[0];
      req_test_ch1    <= px.test_px[1];
      req_test_ch2    <= px.test_px[2];
      do @(posedge clock); while (req_stall);
      expected_heat.insert(expected_heat.size(), predict_heat_stats(px));
   endtask

   // Drop valid and wait until every pending result has come out.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_heat.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Load middle_bound only with the pipeline empty.
   task automatic write_middle_bound(input logic [aehh_pkg::ERR_W-1:0] value);
      drain_pipeline();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      bound_mirror  = value;
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall pattern plus an on-demand long hold-off
   // ------------------------------------------------------------------
   initial begin : rsp_stall_driver
      int n;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            // Hold the output long enough for the pipeline to back up.
            rsp_stall <= 1'b1;
            holding    = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holding      = 1'b0;
            hold_request = 1'b0;
         end else begin
            n = no_idle ? 0 : pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end else begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(6, 1)) @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker: compare each accepted result with the oldest prediction
   // ------------------------------------------------------------------
   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      heat_stats_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_heat.size() == 0) begin
            $error("result transaction with no pixel pending: error %0d", rsp_pixel_error);
            mismatch_count++;
         end else begin
            want = expected_heat.pop_front();
            check_field("pixel_error",  want.pixel_error,  rsp_pixel_error);
            check_field("heat_ch0",     want.heat_ch0,     rsp_heat_ch0);
            check_field("heat_ch1",     want.heat_ch1,     rsp_heat_ch1);
            check_field("heat_ch2",     want.heat_ch2,     rsp_heat_ch2);
            check_field("error_total",  want.error_total,  rsp_error_total);
            check_field("exact_count",  want.exact_count,  rsp_exact_count);
            check_field("middle_count", want.middle_count, rsp_middle_count);
            check_field("bad_count",    want.bad_count,    rsp_bad_count);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Walk the heat steps and the default bin bound, both signs of difference.
   task automatic test_heat_steps();
      int        errs[13];
      pixel_type px;
      errs = '{0, 1, 254, 255, 256, 381, 382, 383, 509, 510, 511, 764, 765};
      for (int i = 0; i < 13; i++)
         send_pixel(pixel_with_error(errs[i], i == 0));
      // Full-scale differences in each direction.
      px.frame_start = 1'b0;
      px.ref_px      = '1;
      px.test_px     = '0;
      send_pixel(px);
      px.ref_px      = '0;
      px.test_px     = '1;
      send_pixel(px);
      // Start a new frame mid-stream; totals must restart with this pixel.
      send_pixel(pixel_with_error(100, 1'b1));
      send_pixel(pixel_with_error(0, 1'b0));
   endtask

   // Zero bound, bounds above the error range and the bound edges.
   task automatic test_bound_extremes();
      int bounds[5];
      int b;
      bounds = '{0, 1023, 765, 766, 1};
      for (int i = 0; i < 5; i++) begin
         write_middle_bound(aehh_pkg::ERR_W'(bounds[i]));
         b = bounds[i];
         send_pixel(pixel_with_error(0, 1'b1));
         send_pixel(pixel_with_error(1, 1'b0));
         send_pixel(pixel_with_error(2, 1'b0));
         send_pixel(pixel_with_error(b, 1'b0));
         send_pixel(pixel_with_error(b + 1, 1'b0));
         send_pixel(pixel_with_error(MAX_ERR, 1'b0));
      end
   endtask

   // Long runs into each bin within one frame, then clear it.
   task automatic test_long_frame();
      write_middle_bound(aehh_pkg::MIDDLE_BOUND_RESET);
      send_pixel(pixel_with_error(0, 1'b1));
      repeat (LONG_RUN) send_pixel(pixel_with_error(0, 1'b0));
      repeat (LONG_RUN) send_pixel(pixel_with_error($urandom_range(382, 1), 1'b0));
      repeat (LONG_RUN) send_pixel(pixel_with_error($urandom_range(765, 383), 1'b0));
      send_pixel(pixel_with_error($urandom_range(765, 0), 1'b1));
   endtask

   // Hold off the result side while the sender keeps offering back to back.
   task automatic test_backpressure();
      drain_pipeline();
      no_idle      = 1'b1;
      hold_request = 1'b1;
      while (!holding)
         @(posedge clock);
      send_pixel(pixel_with_error($urandom_range(765, 0), 1'b1));
      repeat (39) send_pixel(random_pixel(1'b0));
      no_idle = 1'b0;
   endtask

   // Random frames of random length under a range of bounds.
   task automatic test_random_frames();
      int        bounds[8];
      int        frame_left;
      int        kind;
      bit        fs;
      pixel_type px;
      bounds = '{382, 0, 1023, 765, 766, 1, 510, 0};
      bounds[7] = $urandom_range(1023, 0);
      frame_left = 0;
      for (int phase = 0; phase < 8; phase++) begin
         write_middle_bound(aehh_pkg::ERR_W'(bounds[phase]));
         // Keep two phases free of any idling on either side.
         no_idle = (phase == 3 || phase == 6);
         for (int n = 0; n < 220; n++) begin
            if (frame_left == 0) begin
               fs = 1'b1;
               frame_left = $urandom_range(80, 1);
            end else begin
               // Occasionally restart a frame out of turn.
               fs = ($urandom_range(99, 0) < 3);
            end
            frame_left--;
            kind = $urandom_range(3, 0);
            case (kind)
               0, 1:    px = random_pixel(fs);
               2:       px = pixel_with_error($urandom_range(765, 0), fs);
               default: px = pixel_with_error(near_boundary(), fs);
            endcase
            send_pixel(px);
         end
      end
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence: reset once, run the tests in turn, then report
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The first test relies on the reset value of middle_bound.
      test_heat_steps();
      test_bound_extremes();
      test_long_frame();
      test_backpressure();
      test_random_frames();

      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("abs_error_heatmap_histogram: match");
      end else begin
         $display("abs_error_heatmap_histogram: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("abs_error_heatmap_histogram: mismatch");
      $finish;
   end

endmodule
